### hdl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, codes and helper functions of the quintic trajectory
// evaluator.
// ----------------------------------------------------------------------------
package qte_pkg;

   // Field widths
   localparam int TIME_W      = 32;   // unsigned Q8.24 sample time
   localparam int TIME_FRAC_W = 24;   // fraction bits of the time format
   localparam int CSR_DATA_W  = 64;   // coefficient register width, Q16.48
   localparam int OUT_W       = 32;   // signed Q16.16 result
   localparam int REGION_W    = 2;

   // Polynomial structure
   localparam int NUM_COEF  = 6;      // c5 .. c0
   localparam int NUM_STEPS = 5;      // Horner steps of the position polynomial
   localparam int NUM_POLY  = 3;      // position, velocity, acceleration

   // Datapath widths: a stored coefficient holds up to 20 * c5, and each
   // Horner step grows the accumulator by one 32-bit time factor plus a carry.
   localparam int LIMB_W    = TIME_W;
   localparam int COEF_W    = CSR_DATA_W + 5;
   localparam int STEP_GROW = TIME_W + 1;
   localparam int MAX_W     = COEF_W + STEP_GROW * NUM_STEPS;

   // Binary point of the position sum: 48 coefficient fraction bits plus
   // 5 * 24 time fraction bits, less the 16 result fraction bits.
   localparam int POS_SHIFT = 152;

   // Clamp stage, two register stages per Horner step, output stage
   localparam int PIPE_STAGES = 2 * NUM_STEPS + 2;
   localparam int TE_STAGES   = 2 * NUM_STEPS - 1;

   // Saturation limits of the result format
   localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   // Register map
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COEF_T5    = 3'd0,
      CSR_COEF_T4    = 3'd1,
      CSR_COEF_T3    = 3'd2,
      CSR_COEF_T2    = 3'd3,
      CSR_COEF_T1    = 3'd4,
      CSR_COEF_T0    = 3'd5,
      CSR_START_TIME = 3'd6,
      CSR_END_TIME   = 3'd7
   } csr_index_type;

   // Where the sample time fell relative to the interval
   typedef enum logic [REGION_W-1:0] {
      REGION_START  = 2'd0,
      REGION_INSIDE = 2'd1,
      REGION_END    = 2'd2
   } region_type;

   // Accumulator width after the given number of Horner steps
   function automatic int step_width(input int steps);
      return COEF_W + STEP_GROW * steps;
   endfunction

   // Derivative factor of the coefficient of t^power for derivative order
   function automatic int coef_factor(input int order, input int power);
      int f;
      case (order)
         0: f = 1;
         1: f = power;
         default: f = power * (power - 1);
      endcase
      return f;
   endfunction

endpackage

### hdl/qte_horner_step.sv
// ----------------------------------------------------------------------------
// qte_horner_step
// One Horner step, acc * t + coef * 2^(24 * STEP), over two register stages:
// 32x32 limb products first, then one carry-propagate add.
// ----------------------------------------------------------------------------
module qte_horner_step
   import qte_pkg::*;
#(
   parameter int STEP = 1
) (
   input  logic                                 clock,
   input  logic                                 en_mul,
   input  logic                                 en_add,
   input  logic [TIME_W-1:0]                    sample_t,
   input  logic signed [step_width(STEP-1)-1:0] src_acc,
   input  logic signed [COEF_W-1:0]             coef,
   output logic signed [step_width(STEP)-1:0]   dst_acc
);

   localparam int AW       = step_width(STEP - 1);
   localparam int OW       = step_width(STEP);
   localparam int NL       = (AW + LIMB_W - 1) / LIMB_W;
   localparam int VW       = LIMB_W * (NL + 1);
   localparam int XW       = VW + 1;
   localparam int SHIFT    = TIME_FRAC_W * STEP;
   localparam bit TOP_EVEN = ((NL - 1) % 2) == 0;

   logic [LIMB_W*NL-1:0]   acc_ext;
   logic [2*LIMB_W-1:0]    prod_in [NL];
   logic [2*LIMB_W-1:0]    prod_ff [NL];
   logic [VW-1:0]          vec_even;
   logic [VW-1:0]          vec_odd;
   logic [XW-1:0]          even_x;
   logic [XW-1:0]          odd_x;
   logic [XW-1:0]          coef_x;
   logic [XW-1:0]          sum_x;
   logic signed [OW-1:0]   acc_in;
   logic signed [OW-1:0]   acc_ff;

   // Sign-extend the accumulator to whole limbs
   assign acc_ext = (LIMB_W*NL)'(src_acc);

   // Multiply each limb by the time; the top limb carries the sign
   for (genvar i = 0; i < NL; i++) begin : g_limb
      if (i == NL - 1) begin : g_top
         logic signed [LIMB_W:0]     a_s;
         logic signed [LIMB_W:0]     b_s;
         logic signed [2*LIMB_W+1:0] p_s;
         assign a_s        = (LIMB_W+1)'($signed(acc_ext[LIMB_W*i +: LIMB_W]));
         assign b_s        = $signed({1'b0, sample_t});
         assign p_s        = a_s * b_s;
         assign prod_in[i] = p_s[2*LIMB_W-1:0];
      end else begin : g_low
         assign prod_in[i] = (2*LIMB_W)'(acc_ext[LIMB_W*i +: LIMB_W])
                           * (2*LIMB_W)'(sample_t);
      end
   end

   // Hold the partial products
   always_ff @(posedge clock) begin
      if (en_mul) begin
         prod_ff <= prod_in;
      end
   end

   // Even and odd products do not overlap: pack them into two words
   always_comb begin
      vec_even = '0;
      vec_odd  = '0;
      for (int i = 0; i < NL; i++) begin
         if (i[0]) begin
            vec_odd[LIMB_W*i +: 2*LIMB_W] = prod_ff[i];
         end else begin
            vec_even[LIMB_W*i +: 2*LIMB_W] = prod_ff[i];
         end
      end
   end

   // Extend the word holding the signed top product with its sign
   if (TOP_EVEN) begin : g_top_even
      assign even_x = XW'(signed'(vec_even));
      assign odd_x  = XW'(vec_odd);
   end else begin : g_top_odd
      assign even_x = XW'(vec_even);
      assign odd_x  = XW'(signed'(vec_odd));
   end

   // Add the aligned coefficient
   assign coef_x = XW'(coef);
   assign sum_x  = even_x + odd_x + (coef_x << SHIFT);
   assign acc_in = sum_x[OW-1:0];

   always_ff @(posedge clock) begin
      if (en_add) begin
         acc_ff <= acc_in;
      end
   end

   assign dst_acc = acc_ff;

endmodule

### hdl/qte_round_stage.sv
// ----------------------------------------------------------------------------
// qte_round_stage
// Round a wide fixed-point sum to Q16.16 (half up) and saturate to 32 bits.
// ----------------------------------------------------------------------------
module qte_round_stage
   import qte_pkg::*;
#(
   parameter int IN_W  = MAX_W,
   parameter int SHIFT = POS_SHIFT
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [IN_W-1:0] src_acc,
   output logic [OUT_W-1:0]       value_out,
   output logic                   sat_out
);

   localparam int QW = IN_W + 1 - SHIFT;

   logic signed [IN_W:0]    sum_x;
   logic [QW-1:0]           quot;
   logic [QW-OUT_W:0]       upper;
   logic                    in_range;
   logic [OUT_W-1:0]        value_in;
   logic [OUT_W-1:0]        value_ff;
   logic                    sat_in;
   logic                    sat_ff;

   // Add one half, then drop the fraction
   assign sum_x = (IN_W+1)'(src_acc) + ((IN_W+1)'(1) << (SHIFT - 1));
   assign quot  = sum_x[IN_W:SHIFT];

   // In range when every bit above the result agrees with its sign
   assign upper    = quot[QW-1:OUT_W-1];
   assign in_range = (&upper) | ~(|upper);

   assign value_in = in_range ? quot[OUT_W-1:0] : (quot[QW-1] ? SAT_MIN : SAT_MAX);
   assign sat_in   = ~in_range;

   always_ff @(posedge clock) begin
      if (en) begin
         value_ff <= value_in;
         sat_ff   <= sat_in;
      end
   end

   assign value_out = value_ff;
   assign sat_out   = sat_ff;

endmodule

### hdl/quintic_trajectory_evaluator.sv
// ----------------------------------------------------------------------------
// quintic_trajectory_evaluator
// Position, velocity and acceleration of a quintic polynomial trajectory.
//
// Software loads c5..c0 (Q16.48) and the start and end times (Q8.24) on the
// csr_ write port; csr_ready is always high. Each word on req_ carries one
// sample time; each word on rsp_ returns position, velocity and acceleration
// (Q16.16, rounded and saturated), the clamp region and a saturation flag.
// The sample time is clamped to the interval in the first stage, then three
// Horner chains of 32x32 limb multipliers run side by side, two register
// stages per step, and a last stage rounds and saturates. The pipe has
// 12 register stages and takes one word per clock while rsp_stall is low.
// Each stage moves on whenever it or the stage after it is free, so a
// stalled rsp_ side fills the empty stages before req_stall rises, and no
// word is lost or repeated.
// Reset clears all coefficients and both times to zero and empties the pipe.
// Write registers only while no word is in flight.
// ----------------------------------------------------------------------------
module quintic_trajectory_evaluator
   import qte_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [TIME_W-1:0]      req_sample_time,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [OUT_W-1:0]       rsp_position,
   output logic [OUT_W-1:0]       rsp_velocity,
   output logic [OUT_W-1:0]       rsp_acceleration,
   output logic [REGION_W-1:0]    rsp_region,
   output logic                   rsp_saturated,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [NUM_COEF-1:0]      coef_we;
   logic                     start_we;
   logic                     end_we;
   logic [TIME_W-1:0]        start_time_in;
   logic [TIME_W-1:0]        start_time_ff;
   logic [TIME_W-1:0]        end_time_in;
   logic [TIME_W-1:0]        end_time_ff;

   logic [PIPE_STAGES-1:0]   valid_ff;
   logic [PIPE_STAGES-1:0]   valid_in;
   logic [PIPE_STAGES-1:0]   valid_src;
   logic [PIPE_STAGES:0]     ready;

   logic [TIME_W-1:0]        te_in     [TE_STAGES];
   logic [TIME_W-1:0]        te_ff     [TE_STAGES];
   region_type               region_in [PIPE_STAGES];
   region_type               region_ff [PIPE_STAGES];

   logic [OUT_W-1:0]         res_value [NUM_POLY];
   logic [NUM_POLY-1:0]      res_sat;

   // Decode register writes
   assign csr_ready = 1'b1;

   always_comb begin
      coef_we  = '0;
      start_we = 1'b0;
      end_we   = 1'b0;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_COEF_T5:    coef_we[0] = 1'b1;
            CSR_COEF_T4:    coef_we[1] = 1'b1;
            CSR_COEF_T3:    coef_we[2] = 1'b1;
            CSR_COEF_T2:    coef_we[3] = 1'b1;
            CSR_COEF_T1:    coef_we[4] = 1'b1;
            CSR_COEF_T0:    coef_we[5] = 1'b1;
            CSR_START_TIME: start_we   = 1'b1;
            CSR_END_TIME:   end_we     = 1'b1;
            default: ;
         endcase
      end
   end

   assign start_time_in = start_we ? csr_wdata[TIME_W-1:0] : start_time_ff;
   assign end_time_in   = end_we   ? csr_wdata[TIME_W-1:0] : end_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_time_ff <= '0;
         end_time_ff   <= '0;
      end else begin
         start_time_ff <= start_time_in;
         end_time_ff   <= end_time_in;
      end
   end

   // Advance a stage when it is empty or the next one advances
   assign ready[PIPE_STAGES] = ~rsp_stall;
   for (genvar i = 0; i < PIPE_STAGES; i++) begin : g_ready
      assign ready[i] = ~valid_ff[i] | ready[i+1];
   end

   assign valid_src = {valid_ff[PIPE_STAGES-2:0], req_valid};
   assign valid_in  = (valid_src & ready[PIPE_STAGES-1:0])
                    | (valid_ff & ~ready[PIPE_STAGES-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = ~ready[0];
   assign rsp_valid = valid_ff[PIPE_STAGES-1];

   // Clamp the sample time to the interval; the end check wins
   always_comb begin
      if (req_sample_time > end_time_ff) begin
         te_in[0]     = end_time_ff;
         region_in[0] = REGION_END;
      end else if (req_sample_time <= start_time_ff) begin
         te_in[0]     = start_time_ff;
         region_in[0] = REGION_START;
      end else begin
         te_in[0]     = req_sample_time;
         region_in[0] = REGION_INSIDE;
      end
      if (!ready[0]) begin
         te_in[0]     = te_ff[0];
         region_in[0] = region_ff[0];
      end
   end

   // Carry the clamped time and region down the pipe
   for (genvar i = 1; i < TE_STAGES; i++) begin : g_te
      assign te_in[i] = ready[i] ? te_ff[i-1] : te_ff[i];
   end

   for (genvar i = 1; i < PIPE_STAGES; i++) begin : g_region
      assign region_in[i] = ready[i] ? region_ff[i-1] : region_ff[i];
   end

   always_ff @(posedge clock) begin
      te_ff     <= te_in;
      region_ff <= region_in;
   end

   // One Horner chain per derivative order, all ending in the same stage
   for (genvar d = 0; d < NUM_POLY; d++) begin : g_poly
      localparam int NCOEF = NUM_COEF - d;
      localparam int NSTEP = NUM_STEPS - d;

      logic signed [COEF_W-1:0] coef_in [NCOEF];
      logic signed [COEF_W-1:0] coef_ff [NCOEF];
      logic signed [MAX_W-1:0]  acc_bus [NSTEP+1];

      // Store each coefficient already scaled by its derivative factor
      for (genvar k = 0; k < NCOEF; k++) begin : g_coef
         localparam int FACTOR = coef_factor(d, NUM_COEF - 1 - k);

         assign coef_in[k] = coef_we[k]
                           ? COEF_W'(signed'(csr_wdata)) * COEF_W'(FACTOR)
                           : coef_ff[k];

         always_ff @(posedge clock) begin
            if (reset) begin
               coef_ff[k] <= '0;
            end else begin
               coef_ff[k] <= coef_in[k];
            end
         end
      end

      assign acc_bus[0] = MAX_W'(coef_ff[0]);

      // Step j of this chain runs in global step j + d
      for (genvar j = 1; j <= NSTEP; j++) begin : g_step
         localparam int S = j + d;

         logic signed [step_width(j)-1:0] step_acc;

         qte_horner_step #(
            .STEP     (j)
         ) u_step (
            .clock    (clock),
            .en_mul   (ready[2*S-1]),
            .en_add   (ready[2*S]),
            .sample_t (te_ff[2*S-2]),
            .src_acc  (acc_bus[j-1][step_width(j-1)-1:0]),
            .coef     (coef_ff[j]),
            .dst_acc  (step_acc)
         );

         assign acc_bus[j] = MAX_W'(step_acc);
      end

      // Each derivative drops 24 fraction bits from the sum
      qte_round_stage #(
         .IN_W      (step_width(NSTEP)),
         .SHIFT     (POS_SHIFT - TIME_FRAC_W * d)
      ) u_round (
         .clock     (clock),
         .en        (ready[PIPE_STAGES-1]),
         .src_acc   (acc_bus[NSTEP][step_width(NSTEP)-1:0]),
         .value_out (res_value[d]),
         .sat_out   (res_sat[d])
      );
   end

   // Drive the result word
   assign rsp_position     = res_value[0];
   assign rsp_velocity     = res_value[1];
   assign rsp_acceleration = res_value[2];
   assign rsp_region       = region_ff[PIPE_STAGES-1];
   assign rsp_saturated    = |res_sat;

endmodule
